@@ sv/twsc_pkg.sv @@
package twsc_pkg;

    localparam int MaxWindows = 128;
    localparam int IdxW       = $clog2(MaxWindows);
    localparam int CntW       = $clog2(MaxWindows + 1);
    localparam int KeyW       = 63;
    localparam int SizeW      = 32;
    localparam int OutW       = 2;

    localparam logic [SizeW-1:0] SizeReset = 32'd86400;
    localparam logic [19:0]      UsPerSec  = 20'd1000000;

    // seconds = ((ts >> PreShift) * SecRecip) >> (57 + RecipShift), exact for 63-bit ts
    localparam int                PreShift   = 6;
    localparam int                RecipShift = 14;
    localparam int                RecipW     = 58;
    localparam logic [RecipW-1:0] SecRecip   = 58'd151115727451828647;

    localparam logic [OutW-1:0] OutcomeHit     = 2'd0;
    localparam logic [OutW-1:0] OutcomeAdded   = 2'd1;
    localparam logic [OutW-1:0] OutcomeNearest = 2'd2;

endpackage

@@ sv/twsc_keygen.sv @@
module twsc_keygen
    import twsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KeyW-1:0]  i_ts,
    input  logic [SizeW-1:0] i_size,
    output logic             o_done,
    output logic [KeyW-1:0]  o_key
);

    typedef enum logic [2:0] {
        S_IDLE, S_RECIP, S_DIV, S_MUL, S_DONE
    } t_state;

    t_state            r_state;
    logic [5:0]        r_cnt;
    logic [KeyW-1:0]   r_q;
    logic [KeyW-1:0]   r_rem;
    logic [SizeW-1:0]  r_div;
    logic [KeyW-1:0]   r_sec;
    logic [KeyW-1:0]   r_acc;
    logic [KeyW-1:0]   r_mcand;
    logic [19:0]       r_mplier;
    logic [RecipW:0]   r_hm;

    logic [KeyW:0]     w_trial;
    logic [KeyW-1:0]   w_shift;
    logic [RecipW:0]   w_hsum;

    always_comb begin
        w_shift = {r_rem[KeyW-2:0], r_q[KeyW-1]};
        w_trial = {1'b0, w_shift} - {{(KeyW+1-SizeW){1'b0}}, r_div};
        w_hsum  = r_hm + {1'b0, (r_q[0] ? SecRecip : {RecipW{1'b0}})};
    end

    assign o_done = (r_state == S_DONE);
    assign o_key  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_q     <= i_ts >> PreShift;
                        r_hm    <= '0;
                        r_cnt   <= 6'd56;
                        r_state <= S_RECIP;
                    end
                end
                S_RECIP: begin
                    r_hm  <= w_hsum >> 1;
                    r_q   <= r_q >> 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_q     <= KeyW'(w_hsum[RecipW:RecipShift+1]);
                        r_sec   <= KeyW'(w_hsum[RecipW:RecipShift+1]);
                        r_rem   <= '0;
                        r_div   <= (i_size == '0) ? 32'd1 : i_size;
                        r_cnt   <= 6'd62;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_trial[KeyW]) begin
                        r_rem <= w_shift;
                        r_q   <= {r_q[KeyW-2:0], 1'b0};
                    end else begin
                        r_rem <= w_trial[KeyW-1:0];
                        r_q   <= {r_q[KeyW-2:0], 1'b1};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_mcand  <= r_sec - (w_trial[KeyW] ? w_shift
                                                           : w_trial[KeyW-1:0]);
                        r_mplier <= UsPerSec;
                        r_acc    <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= {r_mcand[KeyW-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[19:1]};
                    if (r_mplier == 20'd0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sv/twsc_table.sv @@
module twsc_table
    import twsc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IdxW-1:0] i_waddr,
    input  logic [KeyW-1:0] i_wdata,
    input  logic [IdxW-1:0] i_raddr,
    output logic [KeyW-1:0] o_rdata
);

    logic [KeyW-1:0] r_mem [MaxWindows];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/time_window_segregation_classifier_core.sv @@
// Window classifier: each timestamp beat is turned into its window key (microseconds
// to seconds, floor to a multiple of the window size, back to microseconds) by a
// 57-step shift-add multiply with a reciprocal of one million, a 63-step
// shift-subtract division by the window size and a 20-step shift-add multiply.
// The key is then looked up in a 128-entry single-port-read table with a
// registered read, one entry a cycle; a hit ends the walk early and is followed
// by a swap with entry 0. Items are taken one item at a time, from accept to the
// result beat. The result beat is held in an output register; a new timestamp
// is taken once it has been handed over. A window size of zero acts as one
// second. When the table is full a miss returns the stored key nearest to the
// computed one, lowest index on a tie.
module time_window_segregation_classifier_core
    import twsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,   // [62:0] timestamp_us
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [62:0] window_key
    output logic [OutW-1:0]  m_axis_tuser,   // [1:0] outcome
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [SizeW-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_KEY, S_SCAN, S_SWAP, S_OUT
    } t_state;

    t_state           r_state;
    logic [SizeW-1:0] r_size;
    logic [CntW-1:0]  r_count;
    logic [KeyW-1:0]  r_key;
    logic [CntW-1:0]  r_ridx;
    logic [CntW-1:0]  r_didx;
    logic             r_dvld;
    logic [KeyW-1:0]  r_best;
    logic [KeyW-1:0]  r_bdiff;
    logic [KeyW-1:0]  r_e0;
    logic [KeyW-1:0]  r_okey;
    logic [OutW-1:0]  r_outc;

    logic             w_kdone;
    logic [KeyW-1:0]  w_key;
    logic             w_we;
    logic [IdxW-1:0]  w_waddr;
    logic [KeyW-1:0]  w_wdata;
    logic [KeyW-1:0]  w_rdata;
    logic [KeyW-1:0]  w_diff;
    logic             w_hit;
    logic             w_last;
    logic             w_add;

    assign s_axis_tready = (r_state == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {1'b0, r_okey};
    assign m_axis_tuser  = r_outc;
    assign w_diff        = (w_rdata > r_key) ? w_rdata - r_key : r_key - w_rdata;
    assign w_hit         = r_dvld && (w_rdata == r_key);
    assign w_last        = r_dvld && (r_didx == r_count - CntW'(1));
    assign w_add         = ((!r_dvld && r_ridx == r_count) || w_last)
                           && (r_count != CntW'(MaxWindows));

    twsc_keygen u_keygen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_axis_tvalid && s_axis_tready),
        .i_ts    (s_axis_tdata[KeyW-1:0]),
        .i_size  (r_size),
        .o_done  (w_kdone),
        .o_key   (w_key)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_key;
        if (r_state == S_SCAN && w_hit) begin
            w_we    = 1'b1;
            w_waddr = r_didx[IdxW-1:0];
            w_wdata = r_e0;
        end else if (r_state == S_SCAN && w_add) begin
            w_we    = 1'b1;
            w_waddr = r_count[IdxW-1:0];
        end else if (r_state == S_SWAP) begin
            w_we    = 1'b1;
        end
    end

    twsc_table u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ridx[IdxW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= SizeReset;
            r_count <= '0;
            r_dvld  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                r_size <= cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_KEY;
                    end
                end
                S_KEY: begin
                    if (w_kdone) begin
                        r_key   <= w_key;
                        r_ridx  <= '0;
                        r_dvld  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_okey  <= r_key;
                        r_outc  <= OutcomeHit;
                        r_dvld  <= 1'b0;
                        r_state <= S_SWAP;
                    end else if (w_add) begin
                        r_okey  <= r_key;
                        r_outc  <= OutcomeAdded;
                        r_count <= r_count + CntW'(1);
                        r_dvld  <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        if (r_dvld) begin
                            if (r_didx == '0) begin
                                r_e0 <= w_rdata;
                            end
                            if (r_didx == '0 || w_diff < r_bdiff) begin
                                r_best  <= w_rdata;
                                r_bdiff <= w_diff;
                            end
                        end
                        if (w_last) begin
                            r_okey  <= (r_didx == '0 || w_diff < r_bdiff) ? w_rdata : r_best;
                            r_outc  <= OutcomeNearest;
                            r_dvld  <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_didx <= r_ridx;
                            r_dvld <= (r_ridx != r_count);
                            if (r_ridx != r_count) begin
                                r_ridx <= r_ridx + CntW'(1);
                            end
                        end
                    end
                end
                S_SWAP: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ bench/window_classifier_checker.sv @@
module window_classifier_checker
    import twsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [63:0]      m_axis_tdata,
    input  logic [OutW-1:0]  m_axis_tuser,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [SizeW-1:0] cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen,
    output int               o_outcome_seen [3]
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KeyW-1:0] key;
        logic [OutW-1:0] outcome;
    } t_window_result;

    logic [KeyW-1:0]  table_keys [MaxWindows];
    int               table_fill;
    logic [SizeW-1:0] size_sec;
    t_window_result   expected_windows [$];

    function automatic logic [KeyW-1:0] window_key_of(logic [KeyW-1:0] ts);
        logic [63:0] sz;
        logic [63:0] sec;
        logic [63:0] low;
        sz  = (size_sec == 0) ? 64'd1 : {32'd0, size_sec};
        sec = {1'b0, ts} / 64'd1000000;
        low = sec - (sec % sz);
        return KeyW'(low * 64'd1000000);
    endfunction

    task automatic classify(input logic [KeyW-1:0] ts);
        t_window_result r;
        logic [KeyW-1:0] key;
        logic [KeyW-1:0] d;
        logic [KeyW-1:0] best_d;
        bit found;
        key = window_key_of(ts);
        found = 0;
        r.key = key;
        for (int i = 0; i < table_fill && !found; i++) begin
            if (table_keys[i] == key) begin
                table_keys[i] = table_keys[0];
                table_keys[0] = key;
                r.outcome = OutcomeHit;
                found = 1;
            end
        end
        if (!found && table_fill < MaxWindows) begin
            table_keys[table_fill] = key;
            table_fill++;
            r.outcome = OutcomeAdded;
        end else if (!found) begin
            r.key = table_keys[0];
            best_d = (table_keys[0] > key) ? table_keys[0] - key : key - table_keys[0];
            for (int i = 1; i < MaxWindows; i++) begin
                d = (table_keys[i] > key) ? table_keys[i] - key : key - table_keys[i];
                if (d < best_d) begin
                    best_d = d;
                    r.key = table_keys[i];
                end
            end
            r.outcome = OutcomeNearest;
        end
        expected_windows = {expected_windows, r};
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_results_seen = 0;
        o_pending = 0;
        for (int i = 0; i < 3; i++) o_outcome_seen[i] = 0;
    end

    always @(posedge i_clk) begin
        t_window_result w;
        if (!i_rst_n) begin
            table_fill = 0;
            size_sec   = SizeReset;
            expected_windows.delete();
        end else begin
            if (cfg_valid && cfg_ready) size_sec = cfg_data;
            if (s_axis_tvalid && s_axis_tready) classify(s_axis_tdata[KeyW-1:0]);
            if (m_axis_tvalid && m_axis_tready) begin
                o_results_seen++;
                if (expected_windows.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata, 0);
                end else begin
                    w = expected_windows.pop_front();
                    if (w.outcome < 3) o_outcome_seen[w.outcome]++;
                    if (m_axis_tdata != {1'b0, w.key})
                        report_mismatch("window_key", m_axis_tdata, {1'b0, w.key});
                    if (m_axis_tuser != w.outcome)
                        report_mismatch("outcome", m_axis_tuser, w.outcome);
                end
            end
        end
        o_pending = expected_windows.size();
    end
endmodule

@@ bench/time_window_segregation_classifier_core_test.sv @@
module time_window_segregation_classifier_core_test
    import twsc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 20000;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [63:0]      s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [63:0]      m_axis_tdata;
    logic [OutW-1:0]  m_axis_tuser;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [SizeW-1:0] cfg_data;

    int  fail_count;
    int  pending;
    int  results_seen;
    int  outcome_seen [3];
    int  idle_cycles;
    int  beats_sent;
    bit  hold_off;
    logic [KeyW-1:0] recent_ts [$];

    time_window_segregation_classifier_core dut (.*);

    window_classifier_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .cfg_valid, .cfg_ready, .cfg_data,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen), .o_outcome_seen(outcome_seen)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IdleLimit);
        $display("Timeout after %0d idle cycles", IdleLimit);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int mode;
        bit stalled;
        m_axis_tready = 0;
        stalled = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off && !stalled) begin
                m_axis_tready <= 0;
                repeat (2000) @(negedge i_clk);
                stalled = 1;
            end
            mode = $urandom_range(0, 9);
            m_axis_tready <= (mode < 4) ? 1'b1 : (mode < 8) ? ($urandom_range(0, 2) != 0)
                                                            : 1'b0;
        end
    end

    task automatic send_ts(input logic [KeyW-1:0] ts);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {1'b0, ts};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
        if (recent_ts.size() > 40) void'(recent_ts.pop_front());
        recent_ts = {recent_ts, ts};
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int n);
        s_axis_tvalid <= 0;
        s_axis_tdata  <= {$urandom, $urandom};
        repeat (n) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [SizeW-1:0] v);
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        cfg_valid <= 1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 0;
        cfg_data  <= $urandom;
    endtask

    function automatic logic [KeyW-1:0] rand_ts();
        int pick;
        logic [KeyW-1:0] v;
        pick = $urandom_range(0, 9);
        v = {$urandom, $urandom};
        if (pick < 4 && recent_ts.size() > 0)
            return recent_ts[$urandom_range(0, recent_ts.size() - 1)]
                   + KeyW'($urandom_range(0, 3000000));
        if (pick < 7) return KeyW'({$urandom, $urandom}) % 63'd200000000000;
        return v;
    endfunction

    task automatic random_phase(input int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && n > 0; i++, n--) send_ts(rand_ts());
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 300));
        end
        pause_sender(1);
    endtask

    initial begin
        s_axis_tvalid = 0;
        s_axis_tdata  = 0;
        cfg_valid     = 0;
        cfg_data      = 0;
        hold_off      = 0;
        beats_sent    = 0;
        idle_cycles   = 0;
        i_rst_n       = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        send_ts('0);
        send_ts({KeyW{1'b1}});
        send_ts(63'd86399999999);
        send_ts(63'd86400000000);
        send_ts(63'd999999);
        send_ts('0);
        send_ts(63'h5555_5555_5555_5555);
        send_ts(63'h2AAA_AAAA_AAAA_AAAA);
        pause_sender(1);
        write_size('0);
        send_ts(63'd1999999);
        send_ts(63'd2000000);
        send_ts(63'd1500000);
        pause_sender(1);
        write_size({SizeW{1'b1}});
        send_ts({KeyW{1'b1}});
        send_ts(63'd4294967295000000);
        send_ts(63'd4294967294999999);
        pause_sender(1);
        write_size(32'd1);

        // saturate the table, then push misses for nearest-key substitution
        hold_off = 1;
        for (int i = 0; i < 140; i++) send_ts(63'(i) * 63'd7000000 + 63'd5000000);
        pause_sender(1);
        repeat (3000) @(negedge i_clk);
        hold_off = 0;
        random_phase(300);

        write_size(32'd60);
        random_phase(300);
        write_size(32'd3600);
        random_phase(300);
        write_size($urandom);
        random_phase(250);

        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        $display("Sent %0d timestamps, %0d results: %0d hits, %0d added, %0d nearest",
                 beats_sent, results_seen, outcome_seen[0], outcome_seen[1],
                 outcome_seen[2]);
        $display("Window sizes covered: 0, 1, 60, 3600, 86400, max and one random");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
